>>> hw/rtl/tdcb_pkg.sv
// Shared constants and types for the text display cursor buffer.
// Holds the geometry defaults, character codes and item mode codes.
// No dependencies.
package tdcb_pkg;

	// Default display geometry.
	localparam int LINES_DEF   = 3;
	localparam int COLUMNS_DEF = 16;

	// Width of one character cell.
	localparam int CHAR_W = 8;

	// Character codes: control characters recognized by a put item, and the space shown by empty cells.
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	// Item modes. Code 3 is unused and leaves everything unchanged.
	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

endpackage

>>> hw/rtl/tdcb_if.sv
// Handshake channels of the text display cursor buffer: input items and result items.
// Depends on tdcb_pkg for the character width.
interface tdcb_in_if
	import tdcb_pkg::*;
#(
	parameter int POS_W = 6
);
	logic                valid;
	logic                ready;
	logic [1:0]          mode;
	logic [CHAR_W-1:0]   char_code;
	logic [POS_W-1:0]    read_pos;

	modport source (output valid, output mode, output char_code, output read_pos, input ready);
	modport sink   (input valid, input mode, input char_code, input read_pos, output ready);
endinterface

interface tdcb_out_if
	import tdcb_pkg::*;
#(
	parameter int POS_W = 6
);
	logic                valid;
	logic                ready;
	logic [POS_W-1:0]    cursor_pos;
	logic [CHAR_W-1:0]   read_char;

	modport source (output valid, output cursor_pos, output read_char, input ready);
	modport sink   (input valid, input cursor_pos, input read_char, output ready);
endinterface

>>> hw/rtl/tdcb_cursor.sv
// Cursor register and its next-position logic for put and clear items.
// Also produces the cell write request of a printable character. Depends on tdcb_pkg.
module tdcb_cursor
	import tdcb_pkg::*;
#(
	parameter int LINES   = LINES_DEF,
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int POS_W   = $clog2(LINES * COLUMNS + 1),
	parameter int ADDR_W  = $clog2(LINES * COLUMNS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  mode_t               mode,
	input  logic [CHAR_W-1:0]   char_code,
	output logic [POS_W-1:0]    cursor_next,
	output logic                wr_en,
	output logic [ADDR_W-1:0]   wr_addr
);

	localparam int CELLS = LINES * COLUMNS;
	localparam logic [POS_W-1:0] CELLS_P   = POS_W'(CELLS);
	localparam logic [POS_W-1:0] COLUMNS_P = POS_W'(COLUMNS);

	logic [POS_W-1:0] cursor_q;
	logic [POS_W-1:0] base_pos;
	logic [POS_W-1:0] line_start;
	logic [POS_W-1:0] next_line;
	logic [POS_W-1:0] put_pos;

	// Start of the cursor's line; a cursor past the last cell counts as line 0.
	always_comb begin
		base_pos   = (cursor_q >= CELLS_P) ? '0 : cursor_q;
		line_start = '0;
		for (int k = 1; k < LINES; k++) begin
			if (base_pos >= POS_W'(k * COLUMNS)) begin
				line_start = POS_W'(k * COLUMNS);
			end
		end
		next_line = line_start + COLUMNS_P;
		put_pos   = base_pos;
	end

	// Next cursor position and the write of a printable character.
	always_comb begin
		cursor_next = cursor_q;
		wr_en       = 1'b0;
		wr_addr     = put_pos[ADDR_W-1:0];
		unique case (mode)
			MODE_PUT: begin
				unique case (char_code)
					CH_NEWLINE: begin
						cursor_next = (next_line >= CELLS_P) ? '0 : next_line;
					end
					CH_BACKSPACE: begin
						// Backspace at the first cell stays there.
						if (cursor_q != '0) begin
							cursor_next = cursor_q - 1'b1;
						end
					end
					CH_FORMFEED: begin
						cursor_next = '0;
					end
					CH_RETURN: begin
						cursor_next = line_start;
					end
					default: begin
						wr_en       = 1'b1;
						cursor_next = put_pos + 1'b1;
					end
				endcase
			end
			MODE_CLEAR: begin
				cursor_next = '0;
			end
			default: begin
				cursor_next = cursor_q;
			end
		endcase
	end

	// Cursor state, advanced once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (step) begin
			cursor_q <= cursor_next;
		end
	end

endmodule

>>> hw/rtl/tdcb_cell_mem.sv
// Character cell memory with one valid bit per cell; invalid cells read as space.
// Reset and clear items drop all valid bits at once. Depends on tdcb_pkg.
module tdcb_cell_mem
	import tdcb_pkg::*;
#(
	parameter int CELLS  = LINES_DEF * COLUMNS_DEF,
	parameter int POS_W  = $clog2(CELLS + 1),
	parameter int ADDR_W = $clog2(CELLS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  logic [CHAR_W-1:0]   wr_data,
	input  logic                clr,
	input  logic                rd_en,
	input  logic [POS_W-1:0]    rd_pos,
	output logic [CHAR_W-1:0]   rd_char
);

	localparam logic [POS_W-1:0] CELLS_P = POS_W'(CELLS);

	logic [CHAR_W-1:0] mem [CELLS];
	logic [CELLS-1:0]  valid_q;
	logic [CHAR_W-1:0] rdata_q;
	logic              hit_q;
	logic              in_range_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_in_range;

	assign rd_addr     = rd_pos[ADDR_W-1:0];
	assign rd_in_range = (rd_pos < CELLS_P);

	// Storage array: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Valid bits and the read qualifiers that travel with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			hit_q      <= 1'b0;
			in_range_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q      <= rd_in_range && valid_q[rd_addr];
				in_range_q <= rd_in_range;
			end
		end
	end

	// A cell never written since the last clear shows a space; outside the grid, zero.
	always_comb begin
		if (hit_q) begin
			rd_char = rdata_q;
		end else if (in_range_q) begin
			rd_char = CH_SPACE;
		end else begin
			rd_char = '0;
		end
	end

endmodule

>>> hw/rtl/text_display_cursor_buffer_core.sv
// Top level of the text display cursor buffer: input register, cursor and cell memory,
// result register. Depends on tdcb_pkg, tdcb_if, tdcb_cursor and tdcb_cell_mem.
//
// Usage:
//   in_ch carries one item per handshake: mode (put, clear, read), char_code and
//   read_pos. out_ch returns exactly one result item per input item, in order:
//   cursor_pos after the item and read_char (the cell content for a read item,
//   zero otherwise).
//   An item is accepted when valid and ready are both high. It is loaded into
//   the input register, is processed on its way into the result register, and its
//   result is then offered on out_ch from the result register. One item is
//   accepted per cycle while the receiver does not stall; the cursor update and
//   one cell write or read are done as the item moves into the result register.
//   If the receiver stalls, the result stays in the result register and one more
//   item is still taken into the input register; in_ch.ready falls only when both
//   registers hold items. in_ch.ready is always high while out_ch.ready is high.
//   Reset clears the cursor and drops the valid bit of every cell at once, so all
//   cells read as spaces right after reset; a clear item does the same.
module text_display_cursor_buffer_core
	import tdcb_pkg::*;
#(
	parameter int LINES   = LINES_DEF,
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int POS_W   = $clog2(LINES * COLUMNS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	tdcb_in_if.sink          in_ch,
	tdcb_out_if.source       out_ch
);

	localparam int CELLS  = LINES * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);

	// Input register.
	logic              valid_s1;
	logic [1:0]        mode_s1;
	logic [CHAR_W-1:0] char_s1;
	logic [POS_W-1:0]  pos_s1;

	// Result register.
	logic              valid_s2;
	logic [POS_W-1:0]  cursor_s2;
	logic              is_read_s2;

	logic              advance;
	logic              in_ready;
	mode_t             mode_dec;
	logic [POS_W-1:0]  cursor_next;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CHAR_W-1:0] mem_char;

	assign mode_dec = mode_t'(mode_s1);
	assign advance  = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ready = !valid_s1 || advance;
	assign in_ch.ready = in_ready;

	// Input register: loads whenever it is empty or draining.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			mode_s1 <= in_ch.mode;
			char_s1 <= in_ch.char_code;
			pos_s1  <= in_ch.read_pos;
		end
	end

	// Cursor state and next-position logic.
	tdcb_cursor #(
		.LINES   (LINES),
		.COLUMNS (COLUMNS),
		.POS_W   (POS_W),
		.ADDR_W  (ADDR_W)
	) u_cursor (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.mode        (mode_dec),
		.char_code   (char_s1),
		.cursor_next (cursor_next),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr)
	);

	// Character cells.
	tdcb_cell_mem #(
		.CELLS  (CELLS),
		.POS_W  (POS_W),
		.ADDR_W (ADDR_W)
	) u_cells (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (advance && wr_en),
		.wr_addr (wr_addr),
		.wr_data (char_s1),
		.clr     (advance && (mode_dec == MODE_CLEAR)),
		.rd_en   (advance && (mode_dec == MODE_READ)),
		.rd_pos  (pos_s1),
		.rd_char (mem_char)
	);

	// Result register: holds its item until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cursor_s2  <= cursor_next;
			is_read_s2 <= (mode_dec == MODE_READ);
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.cursor_pos = cursor_s2;
	assign out_ch.read_char  = is_read_s2 ? mem_char : '0;

endmodule

>>> hw/rtl/tdcb_checker.sv
// Port-level checks for the text display cursor buffer, bound to the top level.
// Depends on tdcb_pkg and on text_display_cursor_buffer_core.
module tdcb_checker
	import tdcb_pkg::*;
#(
	parameter int CELLS = LINES_DEF * COLUMNS_DEF,
	parameter int POS_W = $clog2(CELLS + 1)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [POS_W-1:0]  cursor_pos,
	input logic [CHAR_W-1:0] read_char
);

	// No result is offered while reset is applied.
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

	// A draining receiver never backs up the input side.
	assert property (@(posedge clk) disable iff (!arst_n) out_ready |-> in_ready)
		else $error("input stalled while the receiver is ready");

	// The cursor never goes beyond the position past the last cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_pos <= POS_W'(CELLS)))
		else $error("cursor position out of range");

	// A stalled result stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cursor_pos) && $stable(read_char))
		else $error("stalled result changed");

endmodule

bind text_display_cursor_buffer_core tdcb_checker #(
	.CELLS (LINES * COLUMNS),
	.POS_W (POS_W)
) u_tdcb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.cursor_pos (out_ch.cursor_pos),
	.read_char  (out_ch.read_char)
);
